// ===== hw/rtl/qtp_pkg.sv =====
`timescale 1ns / 1ps

package qtp_pkg;

    typedef enum logic {
        OP_FWD = 1'b0,
        OP_INV = 1'b1
    } t_op;

    typedef logic signed [15:0] t_quat;
    typedef logic        [17:0] t_weight;
    typedef logic signed [31:0] t_coord;
    typedef logic signed [32:0] t_diff;
    typedef logic signed [29:0] t_coef;
    typedef logic signed [34:0] t_scaled;
    typedef logic signed [50:0] t_qprod;
    typedef logic signed [62:0] t_mprod;

    localparam int ENT_W = 54;
    localparam int ACC_W = 66;

    typedef logic signed [ENT_W-1:0] t_ent_acc;
    typedef logic signed [ACC_W-1:0] t_acc;

    localparam t_ent_acc ONE_Q42  = 54'sd1 <<< 42;
    localparam t_ent_acc ENT_RND  = 54'sd1 <<< 13;
    localparam t_acc     FIN_RND  = 66'sd1 <<< 27;
    localparam t_coef    COEF_MAX = t_coef'({1'b0, {29{1'b1}}});
    localparam t_coef    COEF_MIN = t_coef'({1'b1, {29{1'b0}}});
    localparam t_coord   CRD_MAX  = t_coord'({1'b0, {31{1'b1}}});
    localparam t_coord   CRD_MIN  = t_coord'({1'b1, {31{1'b0}}});

    typedef struct {
        t_op     op;
        t_quat   q [4];
        t_weight weight;
        t_coord  t [3];
        t_coord  p [3];
    } t_in_beat;

    typedef struct {
        t_op    op;
        t_coef  coef [3][3];
        t_diff  opnd [3];
        t_coord bias [3];
    } t_mat_item;

    function automatic t_coef f_entry(input t_ent_acc v);
        t_ent_acc r;
        r = (v + ENT_RND) >>> 14;
        if (r > t_ent_acc'(COEF_MAX)) begin
            return COEF_MAX;
        end else if (r < t_ent_acc'(COEF_MIN)) begin
            return COEF_MIN;
        end
        return r[29:0];
    endfunction

    function automatic t_coord f_finish(input t_acc a);
        t_acc r;
        r = a >>> 28;
        if (r > t_acc'(CRD_MAX)) begin
            return CRD_MAX;
        end else if (r < t_acc'(CRD_MIN)) begin
            return CRD_MIN;
        end
        return r[31:0];
    endfunction

endpackage

// ===== hw/rtl/qtp_in_if.sv =====
`timescale 1ns / 1ps

interface qtp_in_if import qtp_pkg::*; ();
    logic    valid;
    logic    ready;
    t_op     opcode;
    t_quat   quat_x;
    t_quat   quat_y;
    t_quat   quat_z;
    t_quat   quat_w;
    t_weight weight;
    t_coord  trans_x;
    t_coord  trans_y;
    t_coord  trans_z;
    t_coord  point_x;
    t_coord  point_y;
    t_coord  point_z;

    modport source (
        output valid, opcode, quat_x, quat_y, quat_z, quat_w, weight,
               trans_x, trans_y, trans_z, point_x, point_y, point_z,
        input  ready
    );
    modport sink (
        input  valid, opcode, quat_x, quat_y, quat_z, quat_w, weight,
               trans_x, trans_y, trans_z, point_x, point_y, point_z,
        output ready
    );
endinterface

// ===== hw/rtl/qtp_out_if.sv =====
`timescale 1ns / 1ps

interface qtp_out_if import qtp_pkg::*; ();
    logic   valid;
    logic   ready;
    t_coord out_x;
    t_coord out_y;
    t_coord out_z;

    modport source (output valid, out_x, out_y, out_z, input ready);
    modport sink (input valid, out_x, out_y, out_z, output ready);
endinterface

// ===== hw/rtl/qtp_rot_matrix.sv =====
`timescale 1ns / 1ps

module qtp_rot_matrix import qtp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_beat  i_beat,
    output logic      o_valid,
    input  logic      i_ready,
    output t_mat_item o_item
);

    logic    w_en1, w_en2, w_en3;
    logic    r1_v, r2_v, r3_v;

    t_op     r1_op;
    t_scaled r1_s [3];
    t_quat   r1_q [4];
    t_coord  r1_p [3];
    t_coord  r1_t [3];

    t_op     r2_op;
    t_qprod  r2_xx, r2_xy, r2_xz, r2_xw, r2_yy, r2_yz, r2_yw, r2_zz, r2_zw;
    t_coord  r2_p [3];
    t_coord  r2_t [3];

    t_coef   w_a [3][3];
    t_diff   w_d [3];
    t_mat_item n3_item;
    t_mat_item r3_item;

    assign w_en3   = !r3_v || i_ready;
    assign w_en2   = !r2_v || w_en3;
    assign w_en1   = !r1_v || w_en2;
    assign o_ready = w_en1;
    assign o_valid = r3_v;
    assign o_item  = r3_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            if (w_en1) r1_v <= i_valid;
            if (w_en2) r2_v <= r1_v;
            if (w_en3) r3_v <= r2_v;
        end
    end

    // stage 1: scale x, y, z by the weight
    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r1_op <= i_beat.op;
            for (int i = 0; i < 3; i++) begin
                r1_s[i] <= $signed({1'b0, i_beat.weight}) * i_beat.q[i];
                r1_p[i] <= i_beat.p[i];
                r1_t[i] <= i_beat.t[i];
            end
            for (int i = 0; i < 4; i++) begin
                r1_q[i] <= i_beat.q[i];
            end
        end
    end

    // stage 2: weighted quaternion cross products
    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r2_op <= r1_op;
            r2_xx <= r1_s[0] * r1_q[0];
            r2_xy <= r1_s[0] * r1_q[1];
            r2_xz <= r1_s[0] * r1_q[2];
            r2_xw <= r1_s[0] * r1_q[3];
            r2_yy <= r1_s[1] * r1_q[1];
            r2_yz <= r1_s[1] * r1_q[2];
            r2_yw <= r1_s[1] * r1_q[3];
            r2_zz <= r1_s[2] * r1_q[2];
            r2_zw <= r1_s[2] * r1_q[3];
            r2_p  <= r1_p;
            r2_t  <= r1_t;
        end
    end

    // stage 3: round and saturate entries, transpose for forward, pick the operand
    always_comb begin
        w_a[0][0] = f_entry(ONE_Q42 - (t_ent_acc'(r2_yy) + t_ent_acc'(r2_zz)));
        w_a[0][1] = f_entry(t_ent_acc'(r2_xy) + t_ent_acc'(r2_zw));
        w_a[0][2] = f_entry(t_ent_acc'(r2_xz) - t_ent_acc'(r2_yw));
        w_a[1][0] = f_entry(t_ent_acc'(r2_xy) - t_ent_acc'(r2_zw));
        w_a[1][1] = f_entry(ONE_Q42 - (t_ent_acc'(r2_xx) + t_ent_acc'(r2_zz)));
        w_a[1][2] = f_entry(t_ent_acc'(r2_yz) + t_ent_acc'(r2_xw));
        w_a[2][0] = f_entry(t_ent_acc'(r2_xz) + t_ent_acc'(r2_yw));
        w_a[2][1] = f_entry(t_ent_acc'(r2_yz) - t_ent_acc'(r2_xw));
        w_a[2][2] = f_entry(ONE_Q42 - (t_ent_acc'(r2_xx) + t_ent_acc'(r2_yy)));

        n3_item.op = r2_op;
        for (int n = 0; n < 3; n++) begin
            w_d[n] = t_diff'(r2_p[n]) - t_diff'(r2_t[n]);
            n3_item.opnd[n] = (r2_op == OP_INV) ? w_d[n] : t_diff'(r2_p[n]);
            n3_item.bias[n] = r2_t[n];
        end
        for (int o = 0; o < 3; o++) begin
            for (int n = 0; n < 3; n++) begin
                n3_item.coef[o][n] = (r2_op == OP_INV) ? w_a[o][n] : w_a[n][o];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r3_item <= n3_item;
        end
    end

endmodule

// ===== hw/rtl/quat_trans_point_transform_core.sv =====
`timescale 1ns / 1ps
// Channel   Modport  Beat
// i_item    sink     opcode, quat_x/y/z/w, weight, trans_x/y/z, point_x/y/z
// o_res     source   out_x, out_y, out_z
//
// One beat per cycle sustained while the output is ready; six register stages.
// Stages: weight scale, quaternion products, matrix entries, matrix multiply,
// three-term sum, round and saturate.
// Synchronous active-low reset clears the stage valid bits only.
// Each stage holds while the stage after it is full and stalled; bubbles collapse.

module quat_trans_point_transform_core import qtp_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    qtp_in_if.sink   i_item,
    qtp_out_if.source o_res
);

    t_in_beat  w_beat;
    logic      w_m_valid;
    logic      w_m_ready;
    t_mat_item w_m_item;

    logic      w_en4, w_en5, w_en6;
    logic      r4_v, r5_v, r6_v;

    t_mprod    r4_m [3][3];
    t_acc      r4_bias [3];
    t_acc      r5_acc [3];
    t_coord    r6_out [3];

    assign w_beat.op     = i_item.opcode;
    assign w_beat.q[0]   = i_item.quat_x;
    assign w_beat.q[1]   = i_item.quat_y;
    assign w_beat.q[2]   = i_item.quat_z;
    assign w_beat.q[3]   = i_item.quat_w;
    assign w_beat.weight = i_item.weight;
    assign w_beat.t[0]   = i_item.trans_x;
    assign w_beat.t[1]   = i_item.trans_y;
    assign w_beat.t[2]   = i_item.trans_z;
    assign w_beat.p[0]   = i_item.point_x;
    assign w_beat.p[1]   = i_item.point_y;
    assign w_beat.p[2]   = i_item.point_z;

    qtp_rot_matrix u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_item.valid),
        .o_ready (w_m_ready),
        .i_beat  (w_beat),
        .o_valid (w_m_valid),
        .i_ready (w_en4),
        .o_item  (w_m_item)
    );

    assign i_item.ready = w_m_ready;

    assign w_en6 = !r6_v || o_res.ready;
    assign w_en5 = !r5_v || w_en6;
    assign w_en4 = !r4_v || w_en5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
        end else begin
            if (w_en4) r4_v <= w_m_valid;
            if (w_en5) r5_v <= r4_v;
            if (w_en6) r6_v <= r5_v;
        end
    end

    // stage 4: operand times coefficient, rounding folded into the bias
    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            for (int o = 0; o < 3; o++) begin
                for (int n = 0; n < 3; n++) begin
                    r4_m[o][n] <= w_m_item.opnd[n] * w_m_item.coef[o][n];
                end
                if (w_m_item.op == OP_INV) begin
                    r4_bias[o] <= FIN_RND;
                end else begin
                    r4_bias[o] <= (t_acc'(w_m_item.bias[o]) <<< 28) + FIN_RND;
                end
            end
        end
    end

    // stage 5: accumulate
    always_ff @(posedge i_clk) begin
        if (w_en5) begin
            for (int o = 0; o < 3; o++) begin
                r5_acc[o] <= t_acc'(r4_m[o][0]) + t_acc'(r4_m[o][1])
                           + t_acc'(r4_m[o][2]) + r4_bias[o];
            end
        end
    end

    // stage 6: shift to Q16.16 and saturate
    always_ff @(posedge i_clk) begin
        if (w_en6) begin
            for (int o = 0; o < 3; o++) begin
                r6_out[o] <= f_finish(r5_acc[o]);
            end
        end
    end

    assign o_res.valid = r6_v;
    assign o_res.out_x = r6_out[0];
    assign o_res.out_y = r6_out[1];
    assign o_res.out_z = r6_out[2];

    a_fill4: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_m_valid && w_en4 |=> r4_v)
        else $error("matrix beat lost entering multiply stage");

    a_hold5: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r5_v && !w_en6 |=> r5_v && $stable(r5_acc[0]) && $stable(r5_acc[2]))
        else $error("stalled accumulator beat changed or dropped");

    a_drain6: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r6_v && o_res.ready && !r5_v |=> !r6_v)
        else $error("output beat repeated after delivery");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import qtp_pkg::*;

    localparam int     RAND_BEATS = 1500;
    localparam int     CYC_LIMIT  = 400000;
    localparam int     DRAIN_WAIT = 40;

    localparam t_coord ONE  = 32'sh0001_0000;
    localparam t_quat  QMIN = 16'sh8000;
    localparam t_quat  QMAX = 16'sh7FFF;
    localparam t_quat  QONE = 16'sd16384;
    localparam t_quat  QHLF = 16'sd8192;
    localparam t_quat  Q45  = 16'sd11585;
    localparam t_weight WMAX = 18'h3FFFF;
    localparam t_weight WTWO = 18'd32768;
    localparam t_weight W90  = 18'd32769;

    localparam longint ENT_HI = (longint'(1) <<< 29) - 1;
    localparam longint ENT_LO = -(longint'(1) <<< 29);

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } xyz_t;

    typedef struct packed {
        t_op     op;
        t_quat   qx, qy, qz, qw;
        t_weight wt;
        t_coord  tx, ty, tz;
        t_coord  px, py, pz;
        logic    chk;
        t_coord  ex, ey, ez;
    } dir_row_t;

    // op, quaternion x/y/z/w, weight, translation, point, typed check, expected point
    localparam int N_DIR = 18;
    localparam dir_row_t DIR_TAB [N_DIR] = '{
        '{OP_FWD, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 18'd0, 0, 0, 0,
          ONE, 2*ONE, 3*ONE, 1'b1, ONE, 2*ONE, 3*ONE},
        '{OP_INV, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 18'd0, ONE, ONE, ONE,
          5*ONE, -7*ONE, 9*ONE, 1'b1, 4*ONE, -8*ONE, 8*ONE},
        '{OP_FWD, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 18'd0, CRD_MAX, CRD_MAX, CRD_MAX,
          CRD_MAX, CRD_MAX, CRD_MAX, 1'b1, CRD_MAX, CRD_MAX, CRD_MAX},
        '{OP_FWD, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 18'd0, CRD_MIN, CRD_MIN, CRD_MIN,
          CRD_MIN, CRD_MIN, CRD_MIN, 1'b1, CRD_MIN, CRD_MIN, CRD_MIN},
        '{OP_INV, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 18'd0, CRD_MIN, CRD_MIN, CRD_MIN,
          CRD_MAX, CRD_MAX, CRD_MAX, 1'b1, CRD_MAX, CRD_MAX, CRD_MAX},
        '{OP_INV, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 18'd0, CRD_MAX, CRD_MAX, CRD_MAX,
          CRD_MIN, CRD_MIN, CRD_MIN, 1'b1, CRD_MIN, CRD_MIN, CRD_MIN},
        '{OP_FWD, 16'sd0, 16'sd0, 16'sd0, 16'sd0, WMAX, ONE, 2*ONE, 3*ONE,
          -4*ONE, 5*ONE, -6*ONE, 1'b1, -3*ONE, 7*ONE, -3*ONE},
        '{OP_INV, 16'sd0, 16'sd0, 16'sd0, 16'sd0, WMAX, ONE, 2*ONE, 3*ONE,
          0, 0, 0, 1'b1, -ONE, -2*ONE, -3*ONE},
        '{OP_FWD, 16'sd0, 16'sd0, 16'sd0, QONE, WTWO, ONE, -ONE, 32'sd1,
          ONE, 2*ONE, 3*ONE, 1'b0, 0, 0, 0},
        '{OP_FWD, 16'sd0, 16'sd0, Q45, Q45, W90, 0, 0, 0,
          10*ONE, -3*ONE, ONE, 1'b0, 0, 0, 0},
        '{OP_INV, 16'sd0, 16'sd0, Q45, Q45, W90, 2*ONE, 0, -ONE,
          10*ONE, -3*ONE, ONE, 1'b0, 0, 0, 0},
        '{OP_FWD, QONE, 16'sd0, 16'sd0, 16'sd0, WTWO, ONE, ONE, ONE,
          3*ONE, 5*ONE, 7*ONE, 1'b0, 0, 0, 0},
        '{OP_FWD, QMIN, QMIN, QMIN, QMIN, WMAX, 0, 0, 0,
          CRD_MAX, CRD_MIN, CRD_MAX, 1'b0, 0, 0, 0},
        '{OP_INV, QMAX, QMAX, QMAX, QMAX, WMAX, CRD_MAX, CRD_MAX, CRD_MAX,
          CRD_MIN, CRD_MIN, CRD_MIN, 1'b0, 0, 0, 0},
        '{OP_FWD, QMAX, QMIN, QMAX, QMIN, WMAX, -ONE, ONE, -ONE,
          ONE, 32'sd3, -ONE, 1'b0, 0, 0, 0},
        '{OP_INV, QMIN, QMAX, 16'sd0, 16'sd1, 18'd1, 32'sd1, -32'sd1, 32'sd0,
          ONE, ONE, ONE, 1'b0, 0, 0, 0},
        '{OP_FWD, QHLF, QHLF, QHLF, QHLF, WTWO, 0, CRD_MAX, CRD_MIN,
          CRD_MAX, 0, 0, 1'b0, 0, 0, 0},
        '{OP_FWD, 16'sd1, 16'sd0, 16'sd0, 16'sd0, 18'd1, 0, 0, 0,
          32'sd1, -32'sd1, 32'sd7, 1'b0, 0, 0, 0}
    };

    typedef enum logic [1:0] {
        RX_FREE,
        RX_COIN,
        RX_SLOW
    } rx_mode_t;

    logic     i_clk;
    logic     i_rst_n;
    xyz_t     pending_pts [$];
    xyz_t     got_pt;
    xyz_t     want_pt;
    int       miss_cnt;
    int       cyc_cnt;
    int       burst_left;
    int       rx_left;
    rx_mode_t rx_mode;
    t_in_beat cur_beat;
    xyz_t     cur_pt;

    qtp_in_if  item_if ();
    qtp_out_if res_if ();

    quat_trans_point_transform_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_if),
        .o_res   (res_if)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic longint coef_round(input longint v42);
        longint r;
        r = (v42 + (longint'(1) <<< 13)) >>> 14;
        if (r > ENT_HI) begin
            r = ENT_HI;
        end else if (r < ENT_LO) begin
            r = ENT_LO;
        end
        return r;
    endfunction

    function automatic t_coord crd_round(input longint acc44);
        longint r;
        r = (acc44 + (longint'(1) <<< 27)) >>> 28;
        if (r > longint'(CRD_MAX)) begin
            r = longint'(CRD_MAX);
        end else if (r < longint'(CRD_MIN)) begin
            r = longint'(CRD_MIN);
        end
        return t_coord'(r);
    endfunction

    function automatic xyz_t rigid_xform(input t_in_beat b);
        longint k, one42, acc;
        longint qv [4];
        longint sv [3];
        longint pv [3];
        longint tv [3];
        longint dv [3];
        longint rm [3][3];
        longint xx, xy, xz, xw, yy, yz, yw, zz, zw;
        t_coord res [3];
        k = longint'(b.weight);
        one42 = longint'(1) <<< 42;
        for (int i = 0; i < 4; i++) begin
            qv[i] = longint'(b.q[i]);
        end
        for (int i = 0; i < 3; i++) begin
            sv[i] = k * qv[i];
            pv[i] = longint'(b.p[i]);
            tv[i] = longint'(b.t[i]);
            dv[i] = pv[i] - tv[i];
        end
        xx = sv[0] * qv[0]; xy = sv[0] * qv[1]; xz = sv[0] * qv[2]; xw = sv[0] * qv[3];
        yy = sv[1] * qv[1]; yz = sv[1] * qv[2]; yw = sv[1] * qv[3];
        zz = sv[2] * qv[2]; zw = sv[2] * qv[3];
        rm[0][0] = coef_round(one42 - (yy + zz));
        rm[0][1] = coef_round(xy + zw);
        rm[0][2] = coef_round(xz - yw);
        rm[1][0] = coef_round(xy - zw);
        rm[1][1] = coef_round(one42 - (xx + zz));
        rm[1][2] = coef_round(yz + xw);
        rm[2][0] = coef_round(xz + yw);
        rm[2][1] = coef_round(yz - xw);
        rm[2][2] = coef_round(one42 - (xx + yy));
        for (int n = 0; n < 3; n++) begin
            if (b.op == OP_FWD) begin
                acc = tv[n] <<< 28;
                for (int m = 0; m < 3; m++) begin
                    acc += pv[m] * rm[m][n];
                end
            end else begin
                acc = 0;
                for (int m = 0; m < 3; m++) begin
                    acc += dv[m] * rm[n][m];
                end
            end
            res[n] = crd_round(acc);
        end
        return '{x: res[0], y: res[1], z: res[2]};
    endfunction

    function automatic t_coord rand_coord();
        if ($urandom_range(0, 3) != 0) begin
            return t_coord'(int'($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
        end
        return t_coord'($urandom());
    endfunction

    function automatic t_in_beat rand_beat();
        t_in_beat b;
        longint   nrm;
        longint   wt;
        int       kind;
        kind = $urandom_range(0, 9);
        nrm = 0;
        b.op = t_op'($urandom_range(0, 1));
        for (int i = 0; i < 4; i++) begin
            if (kind < 6) begin
                b.q[i] = t_quat'(int'($urandom_range(0, 32768)) - 16384);
            end else begin
                b.q[i] = t_quat'($urandom_range(0, 65535));
            end
            nrm += longint'(b.q[i]) * longint'(b.q[i]);
        end
        b.weight = t_weight'($urandom_range(0, 262143));
        if (kind < 6 && nrm != 0) begin
            // near-unit rotation: weight is 2/|q|^2 in Q4.14
            wt = (longint'(1) <<< 43) / nrm;
            b.weight = (wt > longint'(WMAX)) ? WMAX : t_weight'(wt);
        end else if (kind == 8) begin
            if ($urandom_range(0, 1) == 1) begin
                b.weight = '0;
            end else begin
                for (int i = 0; i < 4; i++) begin
                    b.q[i] = '0;
                end
            end
        end
        for (int i = 0; i < 3; i++) begin
            b.t[i] = rand_coord();
            b.p[i] = rand_coord();
        end
        return b;
    endfunction

    task automatic send_beat(input t_in_beat b, input xyz_t want);
        item_if.valid   <= 1'b1;
        item_if.opcode  <= b.op;
        item_if.quat_x  <= b.q[0];
        item_if.quat_y  <= b.q[1];
        item_if.quat_z  <= b.q[2];
        item_if.quat_w  <= b.q[3];
        item_if.weight  <= b.weight;
        item_if.trans_x <= b.t[0];
        item_if.trans_y <= b.t[1];
        item_if.trans_z <= b.t[2];
        item_if.point_x <= b.p[0];
        item_if.point_y <= b.p[1];
        item_if.point_z <= b.p[2];
        do @(posedge i_clk); while (!item_if.ready);
        pending_pts.push_back(want);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 12);
            item_if.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    task automatic check_axis(input string axis, input t_coord want, input t_coord got);
        if (got !== want) begin
            miss_cnt++;
            if (miss_cnt <= 10) begin
                $display("mismatch %s: expected %0d (%h) got %0d (%h)",
                         axis, want, want, got, got);
            end
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        item_if.valid   = 1'b0;
        item_if.opcode  = OP_FWD;
        item_if.quat_x  = '0;
        item_if.quat_y  = '0;
        item_if.quat_z  = '0;
        item_if.quat_w  = '0;
        item_if.weight  = '0;
        item_if.trans_x = '0;
        item_if.trans_y = '0;
        item_if.trans_z = '0;
        item_if.point_x = '0;
        item_if.point_y = '0;
        item_if.point_z = '0;
        res_if.ready    = 1'b0;
        miss_cnt        = 0;
        cyc_cnt         = 0;
        burst_left      = 0;
        rx_left         = 0;
        rx_mode         = RX_FREE;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < N_DIR; r++) begin
            cur_beat.op     = DIR_TAB[r].op;
            cur_beat.q[0]   = DIR_TAB[r].qx;
            cur_beat.q[1]   = DIR_TAB[r].qy;
            cur_beat.q[2]   = DIR_TAB[r].qz;
            cur_beat.q[3]   = DIR_TAB[r].qw;
            cur_beat.weight = DIR_TAB[r].wt;
            cur_beat.t[0]   = DIR_TAB[r].tx;
            cur_beat.t[1]   = DIR_TAB[r].ty;
            cur_beat.t[2]   = DIR_TAB[r].tz;
            cur_beat.p[0]   = DIR_TAB[r].px;
            cur_beat.p[1]   = DIR_TAB[r].py;
            cur_beat.p[2]   = DIR_TAB[r].pz;
            if (DIR_TAB[r].chk) begin
                cur_pt = '{x: DIR_TAB[r].ex, y: DIR_TAB[r].ey, z: DIR_TAB[r].ez};
            end else begin
                cur_pt = rigid_xform(cur_beat);
            end
            send_beat(cur_beat, cur_pt);
        end

        for (int n = 0; n < RAND_BEATS; n++) begin
            if (n == RAND_BEATS / 2) begin
                // hold the sender until the pipe is empty
                item_if.valid <= 1'b0;
                while (pending_pts.size() != 0) @(posedge i_clk);
                @(posedge i_clk);
            end
            cur_beat = rand_beat();
            send_beat(cur_beat, rigid_xform(cur_beat));
        end
        item_if.valid <= 1'b0;

        while (pending_pts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        miss_cnt += pending_pts.size();
        if (miss_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 2));
            rx_left <= $urandom_range(10, 150);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_FREE: res_if.ready <= 1'b1;
            RX_COIN: res_if.ready <= ($urandom_range(0, 1) == 1);
            default: res_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got_pt = '{x: res_if.out_x, y: res_if.out_y, z: res_if.out_z};
            if (pending_pts.size() == 0) begin
                miss_cnt++;
                if (miss_cnt <= 10) begin
                    $display("unexpected beat: %h %h %h", got_pt.x, got_pt.y, got_pt.z);
                end
            end else begin
                want_pt = pending_pts.pop_front();
                check_axis("out_x", want_pt.x, got_pt.x);
                check_axis("out_y", want_pt.y, got_pt.y);
                check_axis("out_z", want_pt.z, got_pt.z);
            end
        end
    end

    always @(posedge i_clk) begin
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt == CYC_LIMIT) begin
            $display("timeout with %0d beats outstanding", pending_pts.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

endmodule
